// ===== rtl/mwmb_pkg.sv =====
// shared constants, types and state encodings of the masked window motion blur unit
package mwmb_pkg;

  // image geometry limits
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_RADIUS   = 3;

  // field widths
  localparam int X_W      = $clog2(MAX_WIDTH);
  localparam int Y_W      = $clog2(MAX_HEIGHT);
  localparam int C_W      = $clog2(MAX_CHANNELS);
  localparam int SAMPLE_W = 8;
  localparam int WDT_W    = 7;
  localparam int HGT_W    = 7;
  localparam int CHN_W    = 3;
  localparam int RAD_W    = 2;
  localparam int MASK_W   = 49;
  localparam int TAPS_W   = 6;

  // image store
  localparam int ADDR_W      = Y_W + X_W + C_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

  // window walk
  localparam int MAX_SIDE = 2 * MAX_RADIUS + 1;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int MAX_TAPS = MAX_SIDE * MAX_SIDE;
  localparam int BIT_W    = $clog2(MAX_TAPS);
  localparam int SUM_W    = $clog2(MAX_TAPS * ((1 << SAMPLE_W) - 1) + 1);
  localparam int XO_W     = $clog2(MAX_WIDTH + 2 * MAX_RADIUS);
  localparam int YO_W     = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS);

  // divider step counter
  localparam int DCNT_W = $clog2(SUM_W);

  // register port
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_LSB   = 3;
  localparam int REG_SEL_W = PADDR_W - REG_LSB;

  // register indexes
  localparam logic [REG_SEL_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_KERNEL_RADIUS = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_KERNEL_MASK   = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_TAP_COUNT     = 3'd5;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // window setup seen by the tap walker
  typedef struct packed {
    logic [X_W:0]        width;
    logic [Y_W:0]        height;
    logic [RAD_W-1:0]    radius;
    logic [MASK_W-1:0]   mask;
  } win_cfg_t;

  // walk request from the controller
  typedef struct packed {
    logic           start;
    logic [X_W-1:0] pos_x;
    logic [Y_W-1:0] pos_y;
    logic [C_W-1:0] chan;
  } walk_req_t;

  // controller states
  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SUM,
    CTRL_DIV,
    CTRL_HOLD
  } ctrl_state_e;

  // tap walker states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WALK,
    SEQ_DRAIN
  } seq_state_e;

endpackage

// ===== rtl/mwmb_store.sv =====
// image sample memory with one write port and one registered read port
module mwmb_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [mwmb_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [mwmb_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [mwmb_pkg::ADDR_W-1:0]   raddr_i,
  output logic [mwmb_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [mwmb_pkg::SAMPLE_W-1:0] mem_q [mwmb_pkg::STORE_DEPTH];
  logic [mwmb_pkg::SAMPLE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mwmb_seq.sv =====
// window tap walker: visits one tap a cycle, reads the masked taps inside the image and accumulates their sum
module mwmb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mwmb_pkg::walk_req_t           req_i,
  input  mwmb_pkg::win_cfg_t            cfg_i,
  output logic                         rd_en_o,
  output logic [mwmb_pkg::ADDR_W-1:0]   rd_addr_o,
  input  logic [mwmb_pkg::SAMPLE_W-1:0] rd_data_i,
  output logic                         done_o,
  output logic [mwmb_pkg::SUM_W-1:0]    sum_o
);

  mwmb_pkg::seq_state_e state_q, state_d;

  logic [mwmb_pkg::SIDE_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [mwmb_pkg::BIT_W-1:0]  bit_q, bit_d;
  logic [mwmb_pkg::X_W-1:0]    px_q, px_d;
  logic [mwmb_pkg::Y_W-1:0]    py_q, py_d;
  logic [mwmb_pkg::C_W-1:0]    ch_q, ch_d;
  logic                        take_q, take_d;
  logic                        done_q, done_d;
  logic [mwmb_pkg::SUM_W-1:0]  sum_q, sum_d;

  logic [mwmb_pkg::SIDE_W-1:0] last_idx;
  logic [mwmb_pkg::XO_W-1:0]   tx_off, tx_full;
  logic [mwmb_pkg::YO_W-1:0]   ty_off, ty_full;
  logic                        x_ok, y_ok, tap_en;

  // last offset in the window is twice the radius
  assign last_idx = mwmb_pkg::SIDE_W'({cfg_i.radius, 1'b0});

  // tap position relative to the image
  assign tx_off  = mwmb_pkg::XO_W'(px_q) + mwmb_pkg::XO_W'(dx_q);
  assign ty_off  = mwmb_pkg::YO_W'(py_q) + mwmb_pkg::YO_W'(dy_q);
  assign tx_full = tx_off - mwmb_pkg::XO_W'(cfg_i.radius);
  assign ty_full = ty_off - mwmb_pkg::YO_W'(cfg_i.radius);
  assign x_ok    = (tx_off >= mwmb_pkg::XO_W'(cfg_i.radius)) &&
                   (tx_full < mwmb_pkg::XO_W'(cfg_i.width));
  assign y_ok    = (ty_off >= mwmb_pkg::YO_W'(cfg_i.radius)) &&
                   (ty_full < mwmb_pkg::YO_W'(cfg_i.height));
  assign tap_en  = (state_q == mwmb_pkg::SEQ_WALK) && x_ok && y_ok && cfg_i.mask[bit_q];

  assign rd_en_o   = tap_en;
  assign rd_addr_o = {ty_full[mwmb_pkg::Y_W-1:0], tx_full[mwmb_pkg::X_W-1:0], ch_q};
  assign done_o    = done_q;
  assign sum_o     = sum_q;

  // walk sequencing and accumulation
  always_comb begin
    state_d = state_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    bit_d   = bit_q;
    px_d    = px_q;
    py_d    = py_q;
    ch_d    = ch_q;
    take_d  = tap_en;
    done_d  = 1'b0;
    sum_d   = take_q ? sum_q + mwmb_pkg::SUM_W'(rd_data_i) : sum_q;
    case (state_q)
      mwmb_pkg::SEQ_IDLE: begin
        if (req_i.start) begin
          px_d    = req_i.pos_x;
          py_d    = req_i.pos_y;
          ch_d    = req_i.chan;
          dx_d    = '0;
          dy_d    = '0;
          bit_d   = '0;
          sum_d   = '0;
          state_d = mwmb_pkg::SEQ_WALK;
        end
      end
      mwmb_pkg::SEQ_WALK: begin
        bit_d = bit_q + 1'b1;
        if (dx_q == last_idx) begin
          dx_d = '0;
          if (dy_q == last_idx) begin
            state_d = mwmb_pkg::SEQ_DRAIN;
          end else begin
            dy_d = dy_q + 1'b1;
          end
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      mwmb_pkg::SEQ_DRAIN: begin
        // last tap data lands in the sum at this edge
        done_d  = 1'b1;
        state_d = mwmb_pkg::SEQ_IDLE;
      end
      default: begin
        state_d = mwmb_pkg::SEQ_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwmb_pkg::SEQ_IDLE;
      take_q  <= 1'b0;
      done_q  <= 1'b0;
      dx_q    <= '0;
      dy_q    <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      take_q  <= take_d;
      done_q  <= done_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      bit_q   <= bit_d;
    end
  end

  // position and sum registers
  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    ch_q  <= ch_d;
    sum_q <= sum_d;
  end

endmodule

// ===== rtl/mwmb_divider.sv =====
// radix-2 restoring divider, one quotient bit a cycle, quotient saturated to a sample
module mwmb_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mwmb_pkg::SUM_W-1:0]    dividend_i,
  input  logic [mwmb_pkg::TAPS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [mwmb_pkg::SAMPLE_W-1:0] quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [mwmb_pkg::DCNT_W-1:0]  cnt_q, cnt_d;
  logic [mwmb_pkg::SUM_W-1:0]   quo_q, quo_d;
  logic [mwmb_pkg::TAPS_W-1:0]  rem_q, rem_d;
  logic [mwmb_pkg::TAPS_W-1:0]  div_q, div_d;
  logic [mwmb_pkg::TAPS_W:0]    rem_sh;
  logic                         fits;

  // shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, quo_q[mwmb_pkg::SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      // a zero tap count divides by one
      div_d  = (divisor_i == '0) ? mwmb_pkg::TAPS_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? mwmb_pkg::TAPS_W'(rem_sh - {1'b0, div_q})
                   : rem_sh[mwmb_pkg::TAPS_W-1:0];
      quo_d = {quo_q[mwmb_pkg::SUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mwmb_pkg::DCNT_W'(mwmb_pkg::SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // quotient above the sample range saturates
  assign quotient_o = (|quo_q[mwmb_pkg::SUM_W-1:mwmb_pkg::SAMPLE_W]) ?
                      '1 : quo_q[mwmb_pkg::SAMPLE_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== rtl/masked_window_motion_blur_unit.sv =====
// top level of the masked window motion blur unit: registers, control and result stage
// A write transaction stores one 8-bit sample at (pos_x, pos_y, chan); writes can be
// accepted back to back. A read transaction returns the masked window sum divided by the
// tap count. The tap walker visits every tap of the (2r+1) x (2r+1) window, one tap a
// cycle, reading the image memory only for masked taps inside the image, and a restoring
// divider then produces one quotient bit a cycle; the input is not ready from acceptance
// of a read until its result enters the output register. A read outside the configured
// image answers zero with out_of_range set, by way of the hold state and the output
// register. The result sits in an output register, so the next transaction can be taken
// while a result waits. Registers are at byte offsets 8*i on a 64-bit register port and
// must only be written while the unit is idle. The image memory is not cleared; read only
// positions that have been written.
module masked_window_motion_blur_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwmb_pkg::PADDR_W-1:0]  paddr,
  input  logic [mwmb_pkg::PDATA_W-1:0]  pwdata,
  output logic [mwmb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [mwmb_pkg::X_W-1:0]      pos_x_i,
  input  logic [mwmb_pkg::Y_W-1:0]      pos_y_i,
  input  logic [mwmb_pkg::C_W-1:0]      chan_i,
  input  logic [mwmb_pkg::SAMPLE_W-1:0] sample_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwmb_pkg::SAMPLE_W-1:0] blurred_value_o,
  output logic                          out_of_range_o
);

  // register reset values
  localparam logic [mwmb_pkg::WDT_W-1:0]  RST_WIDTH  = mwmb_pkg::WDT_W'(64);
  localparam logic [mwmb_pkg::HGT_W-1:0]  RST_HEIGHT = mwmb_pkg::HGT_W'(64);
  localparam logic [mwmb_pkg::CHN_W-1:0]  RST_CHANS  = mwmb_pkg::CHN_W'(3);
  localparam logic [mwmb_pkg::RAD_W-1:0]  RST_RADIUS = '0;
  localparam logic [mwmb_pkg::MASK_W-1:0] RST_MASK   = mwmb_pkg::MASK_W'(1);
  localparam logic [mwmb_pkg::TAPS_W-1:0] RST_TAPS   = mwmb_pkg::TAPS_W'(1);

  logic [mwmb_pkg::WDT_W-1:0]  cfg_width_q;
  logic [mwmb_pkg::HGT_W-1:0]  cfg_height_q;
  logic [mwmb_pkg::CHN_W-1:0]  cfg_chans_q;
  logic [mwmb_pkg::RAD_W-1:0]  cfg_radius_q;
  logic [mwmb_pkg::MASK_W-1:0] cfg_mask_q;
  logic [mwmb_pkg::TAPS_W-1:0] cfg_taps_q;

  logic                           reg_wr;
  logic [mwmb_pkg::REG_SEL_W-1:0] reg_sel;

  logic [mwmb_pkg::X_W:0]     width_sat;
  logic [mwmb_pkg::Y_W:0]     height_sat;
  logic [mwmb_pkg::CHN_W-1:0] chans_sat;
  logic [mwmb_pkg::RAD_W-1:0] radius_sat;
  logic                       in_bounds;
  mwmb_pkg::win_cfg_t         win_cfg;

  mwmb_pkg::ctrl_state_e state_q, state_d;
  mwmb_pkg::walk_req_t   walk_req;

  logic                          accept;
  logic                          store_we;
  logic                          rd_en;
  logic [mwmb_pkg::ADDR_W-1:0]   rd_addr;
  logic [mwmb_pkg::SAMPLE_W-1:0] rd_data;
  logic                          walk_done;
  logic [mwmb_pkg::SUM_W-1:0]    walk_sum;
  logic                          div_start;
  logic                          div_done;
  logic [mwmb_pkg::SAMPLE_W-1:0] quotient;

  logic [mwmb_pkg::SAMPLE_W-1:0] res_val_q, res_val_d;
  logic                          res_oor_q, res_oor_d;
  logic                          out_load;
  logic                          out_valid_q, out_valid_d;
  logic [mwmb_pkg::SAMPLE_W-1:0] out_val_q;
  logic                          out_oor_q;

  // register port decode
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[mwmb_pkg::PADDR_W-1:mwmb_pkg::REG_LSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_WIDTH;
      cfg_height_q <= RST_HEIGHT;
      cfg_chans_q  <= RST_CHANS;
      cfg_radius_q <= RST_RADIUS;
      cfg_mask_q   <= RST_MASK;
      cfg_taps_q   <= RST_TAPS;
    end else if (reg_wr) begin
      case (reg_sel)
        mwmb_pkg::REG_IMAGE_WIDTH:   cfg_width_q  <= pwdata[mwmb_pkg::WDT_W-1:0];
        mwmb_pkg::REG_IMAGE_HEIGHT:  cfg_height_q <= pwdata[mwmb_pkg::HGT_W-1:0];
        mwmb_pkg::REG_CHANNEL_COUNT: cfg_chans_q  <= pwdata[mwmb_pkg::CHN_W-1:0];
        mwmb_pkg::REG_KERNEL_RADIUS: cfg_radius_q <= pwdata[mwmb_pkg::RAD_W-1:0];
        mwmb_pkg::REG_KERNEL_MASK:   cfg_mask_q   <= pwdata[mwmb_pkg::MASK_W-1:0];
        mwmb_pkg::REG_TAP_COUNT:     cfg_taps_q   <= pwdata[mwmb_pkg::TAPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      mwmb_pkg::REG_IMAGE_WIDTH:   prdata = mwmb_pkg::PDATA_W'(cfg_width_q);
      mwmb_pkg::REG_IMAGE_HEIGHT:  prdata = mwmb_pkg::PDATA_W'(cfg_height_q);
      mwmb_pkg::REG_CHANNEL_COUNT: prdata = mwmb_pkg::PDATA_W'(cfg_chans_q);
      mwmb_pkg::REG_KERNEL_RADIUS: prdata = mwmb_pkg::PDATA_W'(cfg_radius_q);
      mwmb_pkg::REG_KERNEL_MASK:   prdata = mwmb_pkg::PDATA_W'(cfg_mask_q);
      mwmb_pkg::REG_TAP_COUNT:     prdata = mwmb_pkg::PDATA_W'(cfg_taps_q);
      default:                     prdata = '0;
    endcase
  end

  // geometry clipped to the store limits
  assign width_sat  = (cfg_width_q > mwmb_pkg::WDT_W'(mwmb_pkg::MAX_WIDTH)) ?
                      (mwmb_pkg::X_W+1)'(mwmb_pkg::MAX_WIDTH) :
                      (mwmb_pkg::X_W+1)'(cfg_width_q);
  assign height_sat = (cfg_height_q > mwmb_pkg::HGT_W'(mwmb_pkg::MAX_HEIGHT)) ?
                      (mwmb_pkg::Y_W+1)'(mwmb_pkg::MAX_HEIGHT) :
                      (mwmb_pkg::Y_W+1)'(cfg_height_q);
  assign chans_sat  = (cfg_chans_q > mwmb_pkg::CHN_W'(mwmb_pkg::MAX_CHANNELS)) ?
                      mwmb_pkg::CHN_W'(mwmb_pkg::MAX_CHANNELS) : cfg_chans_q;
  assign radius_sat = (cfg_radius_q > mwmb_pkg::RAD_W'(mwmb_pkg::MAX_RADIUS)) ?
                      mwmb_pkg::RAD_W'(mwmb_pkg::MAX_RADIUS) : cfg_radius_q;

  assign win_cfg.width  = width_sat;
  assign win_cfg.height = height_sat;
  assign win_cfg.radius = radius_sat;
  assign win_cfg.mask   = cfg_mask_q;

  // request position inside the configured image
  assign in_bounds = ((mwmb_pkg::X_W+1)'(pos_x_i) < width_sat) &&
                     ((mwmb_pkg::Y_W+1)'(pos_y_i) < height_sat) &&
                     (mwmb_pkg::CHN_W'(chan_i) < chans_sat);

  assign in_ready_o = (state_q == mwmb_pkg::CTRL_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign store_we   = accept && (op_i == mwmb_pkg::OP_WRITE) && in_bounds;

  // walk request
  assign walk_req.start = accept && (op_i == mwmb_pkg::OP_READ) && in_bounds;
  assign walk_req.pos_x = pos_x_i;
  assign walk_req.pos_y = pos_y_i;
  assign walk_req.chan  = chan_i;

  mwmb_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i ({pos_y_i, pos_x_i, chan_i}),
    .wdata_i (sample_in_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mwmb_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (walk_req),
    .cfg_i     (win_cfg),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (walk_done),
    .sum_o     (walk_sum)
  );

  mwmb_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (walk_sum),
    .divisor_i  (cfg_taps_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // transaction control
  always_comb begin
    state_d   = state_q;
    res_val_d = res_val_q;
    res_oor_d = res_oor_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      mwmb_pkg::CTRL_IDLE: begin
        if (accept && (op_i == mwmb_pkg::OP_READ)) begin
          if (in_bounds) begin
            state_d = mwmb_pkg::CTRL_SUM;
          end else begin
            res_val_d = '0;
            res_oor_d = 1'b1;
            state_d   = mwmb_pkg::CTRL_HOLD;
          end
        end
      end
      mwmb_pkg::CTRL_SUM: begin
        if (walk_done) begin
          div_start = 1'b1;
          state_d   = mwmb_pkg::CTRL_DIV;
        end
      end
      mwmb_pkg::CTRL_DIV: begin
        if (div_done) begin
          res_val_d = quotient;
          res_oor_d = 1'b0;
          state_d   = mwmb_pkg::CTRL_HOLD;
        end
      end
      mwmb_pkg::CTRL_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = mwmb_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = mwmb_pkg::CTRL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwmb_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_oor_q <= res_oor_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= res_val_q;
      out_oor_q <= res_oor_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_value_o = out_val_q;
  assign out_of_range_o  = out_oor_q;

endmodule

// ===== rtl/mwmb_checker.sv =====
// port-level checks of the masked window motion blur unit and their binding
module mwmb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          op_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [mwmb_pkg::SAMPLE_W-1:0] blurred_value_o,
  input  logic                          out_of_range_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(blurred_value_o))
    else $error("result changed while stalled");

  // an out of range answer carries a zero value
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> blurred_value_o == '0)
    else $error("out of range result with nonzero value");

  // a read transaction occupies the unit
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == mwmb_pkg::OP_READ) |=> !in_ready_o)
    else $error("read transaction did not make the unit busy");

  // a write transaction leaves the unit ready
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == mwmb_pkg::OP_WRITE) |=> in_ready_o)
    else $error("write transaction stalled the unit");

  // a new result comes with the unit idle again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued while unit still busy");

endmodule

bind masked_window_motion_blur_unit mwmb_checker u_mwmb_checker (.*);
